@@ rtl/sorted_priority_queue_core_macros.svh @@
// Assertion helpers; expect clk_i and rst_ni in the including scope.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PrioW  = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CountW = 5;

  typedef enum logic [OpW-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic signed [DataW-1:0] item_data;
    logic signed [PrioW-1:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_data;
    logic                    empty_error;
    logic                    full_error;
    logic [CountW-1:0]       entry_count;
  } out_item_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic                    shift_in;
    logic                    shift_out;
    logic signed [DataW-1:0] new_data;
    logic signed [PrioW-1:0] new_prio;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/sorted_priority_queue_core.sv @@
// Sorted priority queue built as a row of CAPACITY cells, highest priority in cell 0.
// Input channel (in_valid_i / in_stall_o / in_item_i): one item per operation,
//   enqueue (data, priority), dequeue, or clear; code 3 does nothing.
// Output channel (out_valid_o / out_stall_i / out_item_o): exactly one result
//   per item, with dequeued data, empty and full flags and the entry count.
// Throughput: one item per cycle while the receiver does not stall. All cells
//   compare the new priority in parallel and shift toward or away from the head in
//   the same cycle. The result is registered in the cycle after accept.
// Equal priorities leave in arrival order. An enqueue into a full queue is
//   dropped with full_error; a dequeue on an empty queue sets empty_error.
// Reset clears the entry count and the output valid; cell contents are left
//   as they are and only occupied cells are ever read.
// Receiver stall: while a result is held and out_stall_i is high, in_stall_o
//   is high and no new item is taken; otherwise an item is accepted even
//   while the previous result is being handed over.
`default_nettype none

`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire spq_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output spq_pkg::out_item_t      out_item_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  spq_pkg::out_item_t out_item_q, out_item_d;

  logic accept, is_full, is_empty;
  spq_pkg::cell_ctrl_t ctrl;

  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] keep;
  logic signed [spq_pkg::DataW-1:0] cell_data [CAPACITY];
  logic signed [spq_pkg::PrioW-1:0] cell_prio [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_full    = (count_q == CntW'(CAPACITY));
  assign is_empty   = (count_q == '0);

  assign ctrl.shift_in  = accept && (in_item_i.operation == spq_pkg::OP_ENQUEUE) && !is_full;
  assign ctrl.shift_out = accept && (in_item_i.operation == spq_pkg::OP_DEQUEUE) && !is_empty;
  assign ctrl.new_data  = in_item_i.item_data;
  assign ctrl.new_prio  = in_item_i.item_priority;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                             l_keep;
    logic signed [spq_pkg::DataW-1:0] l_data, r_data;
    logic signed [spq_pkg::PrioW-1:0] l_prio, r_prio;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign l_keep = 1'b1;
      assign l_data = in_item_i.item_data;
      assign l_prio = in_item_i.item_priority;
    end else begin : g_body
      assign l_keep = keep[i-1];
      assign l_data = cell_data[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_data = '0;
      assign r_prio = '0;
    end else begin : g_inner
      assign r_data = cell_data[i+1];
      assign r_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ[i]),
      .left_keep_i  (l_keep),
      .left_data_i  (l_data),
      .left_prio_i  (l_prio),
      .right_data_i (r_data),
      .right_prio_i (r_prio),
      .keep_o       (keep[i]),
      .data_o       (cell_data[i]),
      .prio_o       (cell_prio[i])
    );
  end

  always_comb begin
    count_d    = count_q;
    out_item_d = out_item_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      out_item_d.out_data    = '0;
      out_item_d.empty_error = 1'b0;
      out_item_d.full_error  = 1'b0;
      unique case (in_item_i.operation)
        spq_pkg::OP_ENQUEUE: begin
          if (is_full) begin
            out_item_d.full_error = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        spq_pkg::OP_DEQUEUE: begin
          if (is_empty) begin
            out_item_d.empty_error = 1'b1;
          end else begin
            out_item_d.out_data = cell_data[0];
            count_d = count_q - 1'b1;
          end
        end
        spq_pkg::OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
      out_item_d.entry_count = spq_pkg::CountW'(count_d);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_NEXT(a_enq_count, ctrl.shift_in, count_q == $past(count_q) + 1'b1, "enqueue count")
  `SPQ_ASSERT_NEXT(a_deq_data, ctrl.shift_out, out_item_q.out_data == $past(cell_data[0]), "dequeue data")
  `SPQ_ASSERT_NEXT(a_result, accept, out_valid_q, "accepted item gave no result")

endmodule

`default_nettype wire

@@ rtl/spq_cell.sv @@
`default_nettype none

module spq_cell (
  input  wire logic                            clk_i,
  input  wire spq_pkg::cell_ctrl_t             ctrl_i,
  input  wire logic                            occ_i,
  input  wire logic                            left_keep_i,
  input  wire logic signed [spq_pkg::DataW-1:0] left_data_i,
  input  wire logic signed [spq_pkg::PrioW-1:0] left_prio_i,
  input  wire logic signed [spq_pkg::DataW-1:0] right_data_i,
  input  wire logic signed [spq_pkg::PrioW-1:0] right_prio_i,
  output logic                                 keep_o,
  output logic signed [spq_pkg::DataW-1:0]     data_o,
  output logic signed [spq_pkg::PrioW-1:0]     prio_o
);

  logic signed [spq_pkg::DataW-1:0] data_q, data_d;
  logic signed [spq_pkg::PrioW-1:0] prio_q, prio_d;

  // Stored entry stays ahead of a new one of equal or lower priority.
  assign keep_o = occ_i && !(prio_q < ctrl_i.new_prio);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.shift_in) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          data_d = ctrl_i.new_data;
          prio_d = ctrl_i.new_prio;
        end else begin
          data_d = left_data_i;
          prio_d = left_prio_i;
        end
      end
    end else if (ctrl_i.shift_out) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule

`default_nettype wire
